/* rtl/phcc_pkg.sv */
// Shared types, constants and CRC/checksum functions for the packet header CRC block.
package phcc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned CountW = 9;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'h1021;
  localparam logic [ByteW-1:0] ByteMask = 8'hFF;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             last;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] expected_length;
    logic [CrcW-1:0]  expected_crc;
    logic             header_ok;
  } item_t;

  // Queue fill status as seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Byte-wide CRC-16-CCITT update, MSB first.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Two's complement of the byte sum of id, length and both CRC bytes.
  function automatic logic [ByteW-1:0] neg_sum4(input logic [ByteW-1:0] id,
                                                input logic [ByteW-1:0] len,
                                                input logic [CrcW-1:0]  crc);
    logic [ByteW-1:0] s;
    s = id + len + crc[15:8] + crc[7:0];
    return (s ^ ByteMask) + 8'd1;
  endfunction

endpackage

/* rtl/phcc_front.sv */
// Front end: accepts input items, checks the received header and packs items for the queue.
module phcc_front
  import phcc_pkg::*;
(
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             has_byte,
  input  logic             last,
  input  logic [ByteW-1:0] frame_id,
  input  logic [ByteW-1:0] expected_length,
  input  logic [CrcW-1:0]  expected_crc,
  input  logic [ByteW-1:0] expected_hdr_sum,
  input  queue_status_t    qstat,
  output logic             push,
  output item_t            push_item
);

  // The received header check needs only fields of this item, so it is done here.
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  always_comb begin
    push_item.data_byte       = data_byte;
    push_item.has_byte        = has_byte;
    push_item.last            = last;
    push_item.frame_id        = frame_id;
    push_item.expected_length = expected_length;
    push_item.expected_crc    = expected_crc;
    push_item.header_ok       =
      (neg_sum4(frame_id, expected_length, expected_crc) == expected_hdr_sum);
  end

endmodule

/* rtl/phcc_queue.sv */
// Short FIFO of classified items between the front end and the back end.
module phcc_queue
  import phcc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         push_item,
  input  logic          pop,
  output item_t         pop_item,
  output queue_status_t qstat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  assign qstat.empty = (fill == '0);
  assign qstat.full  = (fill == CntW'(DEPTH));
  assign pop_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

/* rtl/phcc_back.sv */
// Back end: runs the CRC and byte count and builds the result header in an output register.
module phcc_back
  import phcc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  queue_status_t    qstat,
  input  item_t            pop_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] hdr_sum,
  output logic [ByteW-1:0] body_len,
  output logic [CrcW-1:0]  payload_crc,
  output logic             length_overflow,
  output logic             length_ok,
  output logic             crc_ok,
  output logic             header_ok
);

  logic [CrcW-1:0]   crc_acc;
  logic [CountW-1:0] byte_count;
  logic [CrcW-1:0]   crc_next;
  logic [CountW-1:0] count_next;
  logic              out_free;
  logic              ovf;
  logic [ByteW-1:0]  len;

  assign out_free = !out_valid || !out_stall;
  // A result-carrying item waits until the output register can take it.
  assign pop      = !qstat.empty && (!pop_item.last || out_free);

  always_comb begin
    crc_next   = crc_acc;
    count_next = byte_count;
    if (pop_item.has_byte) begin
      crc_next = crc_feed(crc_acc, pop_item.data_byte);
      if (byte_count <= CountW'(MAX_PAYLOAD)) begin
        count_next = byte_count + CountW'(1);
      end
    end
    ovf = (count_next > CountW'(MAX_PAYLOAD));
    len = ovf ? ByteW'(MAX_PAYLOAD) : count_next[ByteW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= CrcInit;
      byte_count <= '0;
    end else if (pop) begin
      if (pop_item.last) begin
        crc_acc    <= CrcInit;
        byte_count <= '0;
      end else begin
        crc_acc    <= crc_next;
        byte_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      hdr_sum         <= neg_sum4(pop_item.frame_id, len, crc_next);
      body_len        <= len;
      payload_crc     <= crc_next;
      length_overflow <= ovf;
      length_ok       <= !ovf && (count_next == {1'b0, pop_item.expected_length});
      crc_ok          <= (crc_next == pop_item.expected_crc);
      header_ok       <= pop_item.header_ok;
    end
  end

endmodule

/* rtl/packet_header_crc_build_check.sv */
// Top level of the packet header CRC builder and checker.
// A last item goes from the input into the queue, and its result into the output register.
// Throughput: one item per cycle while the queue is not full, set by the byte-wide CRC update.
// The item queue between front and back absorbs output stalls for up to QUEUE_DEPTH items.
// Reset (rst, synchronous) empties the queue, clears out_valid, loads the CRC with all ones
// and clears the byte count.
module packet_header_crc_build_check
  import phcc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             has_byte,
  input  logic             last,
  input  logic [ByteW-1:0] frame_id,
  input  logic [ByteW-1:0] expected_length,
  input  logic [CrcW-1:0]  expected_crc,
  input  logic [ByteW-1:0] expected_hdr_sum,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] hdr_sum,
  output logic [ByteW-1:0] body_len,
  output logic [CrcW-1:0]  payload_crc,
  output logic             length_overflow,
  output logic             length_ok,
  output logic             crc_ok,
  output logic             header_ok
);

  // The front end checks the received header of each item and writes the item to the
  // queue. It stalls the input only when the queue is full.
  queue_status_t qstat;
  logic          push;
  item_t         push_item;
  logic          pop;
  item_t         pop_item;

  phcc_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .has_byte         (has_byte),
    .last             (last),
    .frame_id         (frame_id),
    .expected_length  (expected_length),
    .expected_crc     (expected_crc),
    .expected_hdr_sum (expected_hdr_sum),
    .qstat            (qstat),
    .push             (push),
    .push_item        (push_item)
  );

  // The queue lets the input keep flowing while a finished result waits to be taken.
  phcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // The back end folds each byte into the CRC and count. On a last item it builds the
  // header and the check flags into the output register, then restarts the CRC and count.
  // Items that carry no result keep draining even while the output is stalled.
  phcc_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hdr_sum         (hdr_sum),
    .body_len        (body_len),
    .payload_crc     (payload_crc),
    .length_overflow (length_overflow),
    .length_ok       (length_ok),
    .crc_ok          (crc_ok),
    .header_ok       (header_ok)
  );

endmodule

/* sim/header_result_checker.sv */
// Scoreboard for the packet header CRC block: predicts each header result and compares it.
`timescale 1ns / 1ps

module header_result_checker
  import phcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             has_byte,
  input  logic             last,
  input  logic [ByteW-1:0] frame_id,
  input  logic [ByteW-1:0] expected_length,
  input  logic [CrcW-1:0]  expected_crc,
  input  logic [ByteW-1:0] expected_hdr_sum,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [ByteW-1:0] hdr_sum,
  input  logic [ByteW-1:0] body_len,
  input  logic [CrcW-1:0]  payload_crc,
  input  logic             length_overflow,
  input  logic             length_ok,
  input  logic             crc_ok,
  input  logic             header_ok,
  output int unsigned      mismatches,
  output int unsigned      awaiting
);

  localparam int unsigned PayloadLimit = 255;

  typedef struct packed {
    logic [ByteW-1:0] hck;
    logic [ByteW-1:0] len;
    logic [CrcW-1:0]  crc;
    logic             ovf;
    logic             len_ok;
    logic             crc_ok;
    logic             hdr_ok;
  } header_result_t;

  header_result_t   header_results_due[$];
  logic [CrcW-1:0]  crc_run = CrcInit;
  logic [CountW-1:0] bytes_seen = '0;

  // Shift one message bit at a time into the CRC register, MSB of the byte first.
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] acc,
                                               input logic [ByteW-1:0] b);
    logic fb;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb  = acc[CrcW-1] ^ b[i];
      acc = {acc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return acc;
  endfunction

  function automatic logic [ByteW-1:0] negated_byte_sum(input logic [ByteW-1:0] id,
                                                        input logic [ByteW-1:0] len,
                                                        input logic [CrcW-1:0]  crc);
    logic [ByteW-1:0] s;
    s = id + len + crc[15:8] + crc[7:0];
    return ~s + 8'd1;
  endfunction

  task automatic flag(input string what, input logic [CrcW-1:0] got,
                      input logic [CrcW-1:0] want);
    mismatches++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [CrcW-1:0] got,
                               input logic [CrcW-1:0] want);
    if (got !== want) begin
      flag(what, got, want);
    end
  endtask

  always @(posedge clk) begin : watch
    header_result_t got;
    header_result_t want;
    logic           ovf;
    logic [ByteW-1:0] len8;
    if (rst) begin
      crc_run = CrcInit;
      bytes_seen = '0;
      header_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{hdr_sum, body_len, payload_crc, length_overflow,
                length_ok, crc_ok, header_ok};
        if (header_results_due.size() == 0) begin
          flag("result with nothing outstanding", got.crc, '0);
        end else begin
          want = header_results_due.pop_front();
          compare_field("hdr_sum", CrcW'(got.hck), CrcW'(want.hck));
          compare_field("body_len", CrcW'(got.len), CrcW'(want.len));
          compare_field("payload_crc", got.crc, want.crc);
          compare_field("length_overflow", CrcW'(got.ovf), CrcW'(want.ovf));
          compare_field("length_ok", CrcW'(got.len_ok), CrcW'(want.len_ok));
          compare_field("crc_ok", CrcW'(got.crc_ok), CrcW'(want.crc_ok));
          compare_field("header_ok", CrcW'(got.hdr_ok), CrcW'(want.hdr_ok));
        end
      end
      if (in_valid && !in_stall) begin
        if (has_byte) begin
          crc_run = crc_step(crc_run, data_byte);
          if (bytes_seen <= PayloadLimit) begin
            bytes_seen++;
          end
        end
        if (last) begin
          ovf  = bytes_seen > PayloadLimit;
          len8 = ovf ? ByteW'(PayloadLimit) : bytes_seen[ByteW-1:0];
          want.hck    = negated_byte_sum(frame_id, len8, crc_run);
          want.len    = len8;
          want.crc    = crc_run;
          want.ovf    = ovf;
          want.len_ok = !ovf && (bytes_seen == {1'b0, expected_length});
          want.crc_ok = crc_run == expected_crc;
          want.hdr_ok = negated_byte_sum(frame_id, expected_length, expected_crc)
                        == expected_hdr_sum;
          header_results_due.push_back(want);
          crc_run = CrcInit;
          bytes_seen = '0;
        end
      end
    end
    awaiting <= header_results_due.size();
  end

endmodule

/* sim/packet_header_crc_build_check_test.sv */
// Testbench top for the packet header CRC block: drives packets and gives the verdict.
`timescale 1ns / 1ps

module packet_header_crc_build_check_test
  import phcc_pkg::*;
;

  // How the received header that rides on the closing item is built. A good header
  // carries the true length and CRC with a matching checksum; the others break one
  // part of it, or fill it with noise.
  typedef enum int {
    HDR_GOOD,
    HDR_BAD_LEN,
    HDR_BAD_CRC,
    HDR_BAD_SUM,
    HDR_RANDOM
  } hdr_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] data_byte = '0;
  logic             has_byte = 1'b0;
  logic             last = 1'b0;
  logic [ByteW-1:0] frame_id = '0;
  logic [ByteW-1:0] expected_length = '0;
  logic [CrcW-1:0]  expected_crc = '0;
  logic [ByteW-1:0] expected_hdr_sum = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] hdr_sum;
  logic [ByteW-1:0] body_len;
  logic [CrcW-1:0]  payload_crc;
  logic             length_overflow;
  logic             length_ok;
  logic             crc_ok;
  logic             header_ok;

  int unsigned mismatches;
  int unsigned awaiting;

  // Payload of the next packet to send, filled before each call of send_packet.
  logic [ByteW-1:0] payload[$];
  int  items_sent = 0;
  // While set, the sender puts no gaps between items.
  bit  steady = 1'b0;
  int  stall_left = 0;
  int  free_left = 0;

  always #1 clk = ~clk;

  packet_header_crc_build_check u_dut (.*);

  header_result_checker u_checker (.*);

  // The receiver stalls in bursts. Most bursts are short, a few are long, and now
  // and then a calm stretch lets results flow out every cycle.
  always @(posedge clk) begin : out_stall_gen
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        free_left = $urandom_range(20, 80);
      end else if (r < 14) begin
        stall_left = $urandom_range(10, 40);
      end else if (r < 45) begin
        stall_left = $urandom_range(0, 2);
      end
      out_stall <= 1'b0;
    end
  end

  // Mostly back to back, sometimes a short idle gap, rarely a long pause; no gap while steady.
  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic hdr_mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return HDR_GOOD;
    end else if (r < 70) begin
      return HDR_BAD_LEN;
    end else if (r < 80) begin
      return HDR_BAD_CRC;
    end else if (r < 90) begin
      return HDR_BAD_SUM;
    end
    return HDR_RANDOM;
  endfunction

  // Present one item and hold it until the block takes it. The payload only changes
  // at an edge where the item was accepted, so a stalled item stays put. After
  // acceptance the valid is either left high for the next item or lowered for a gap.
  task automatic send_item(input logic [ByteW-1:0] d, input logic h, input logic l,
                           input logic [ByteW-1:0] id, input logic [ByteW-1:0] elen,
                           input logic [CrcW-1:0] ecrc, input logic [ByteW-1:0] hck);
    int gap;
    in_valid <= 1'b1;
    data_byte <= d;
    has_byte <= h;
    last <= l;
    frame_id <= id;
    expected_length <= elen;
    expected_crc <= ecrc;
    expected_hdr_sum <= hck;
    do @(posedge clk); while (in_stall);
    if (h || l) begin
      items_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the queued payload as one packet. The closing item either carries the final
  // byte or comes on its own with no byte. Non-closing items carry noise in the header
  // fields, which the block must ignore. The received header is built with the package
  // routines so that a well-formed one actually matches the payload.
  task automatic send_packet(input logic [ByteW-1:0] id, input hdr_mode_t mode,
                             input bit end_on_byte);
    logic [CrcW-1:0]  crc;
    logic [CrcW-1:0]  ecrc;
    logic [ByteW-1:0] elen;
    logic [ByteW-1:0] hck;
    logic             close_here;
    int               n;
    crc = CrcInit;
    n = payload.size();
    for (int i = 0; i < n; i++) begin
      crc = crc_feed(crc, payload[i]);
    end
    // A payload longer than the limit reports a saturated length.
    elen = (n > 255) ? 8'hFF : ByteW'(n);
    ecrc = crc;
    unique case (mode)
      HDR_BAD_LEN: elen = elen ^ ByteW'($urandom_range(1, 255));
      HDR_BAD_CRC: ecrc = ecrc ^ CrcW'($urandom_range(1, 65535));
      HDR_RANDOM: begin
        elen = ByteW'($urandom);
        ecrc = CrcW'($urandom);
      end
      default: ;
    endcase
    hck = neg_sum4(id, elen, ecrc);
    if (mode == HDR_BAD_SUM) begin
      hck = hck ^ ByteW'($urandom_range(1, 255));
    end else if (mode == HDR_RANDOM) begin
      hck = ByteW'($urandom);
    end
    end_on_byte = end_on_byte && (n > 0);
    for (int i = 0; i < n; i++) begin
      // Now and then an empty item that is not last, which must change nothing.
      if (!steady && $urandom_range(0, 19) == 0) begin
        send_item(ByteW'($urandom), 1'b0, 1'b0, ByteW'($urandom), ByteW'($urandom),
                  CrcW'($urandom), ByteW'($urandom));
      end
      close_here = end_on_byte && (i == n - 1);
      if (close_here) begin
        send_item(payload[i], 1'b1, 1'b1, id, elen, ecrc, hck);
      end else begin
        send_item(payload[i], 1'b1, 1'b0, ByteW'($urandom), ByteW'($urandom),
                  CrcW'($urandom), ByteW'($urandom));
      end
    end
    if (!end_on_byte) begin
      send_item(ByteW'($urandom), 1'b0, 1'b1, id, elen, ecrc, hck);
    end
    payload.delete();
  endtask

  // Hold the sender off until every result already owed has come out. If the last
  // item left the valid high, it is lowered here at the edge that accepted it.
  task automatic wait_for_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin : stimulus
    int packets;
    int n;
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // An empty packet closed right away: length zero and the CRC's initial value.
    send_packet(8'h00, HDR_GOOD, 1'b0);
    // Empty close with every received header field at its maximum.
    send_item(8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    // The usual check string "123456789", whose CRC is 0x29B1, closed on its last byte.
    for (int i = 0; i < 9; i++) begin
      payload.push_back(8'h31 + ByteW'(i));
    end
    send_packet(8'h5A, HDR_GOOD, 1'b1);
    // An ignored empty item with all fields high, then a zero byte closed separately
    // with a wrong length in the received header.
    send_item(8'hFF, 1'b0, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    payload.push_back(8'h00);
    send_packet(8'hFF, HDR_BAD_LEN, 1'b0);
    // A single all-ones byte on the closing item, with a wrong received CRC.
    payload.push_back(8'hFF);
    send_packet(8'h80, HDR_BAD_CRC, 1'b1);
    // Two bytes with a corrupted received header checksum.
    payload.push_back(8'hA5);
    payload.push_back(8'h5A);
    send_packet(8'h01, HDR_BAD_SUM, 1'b0);

    // Random packets. Most are short; two are forced to sit exactly at and just past
    // the length limit, and a rare one of 250 to 300 bytes falls around it to test the overflow flag.
    packets = 0;
    while (items_sent < 800) begin
      r = $urandom_range(0, 99);
      if (packets == 3) begin
        n = 255;
      end else if (packets == 7) begin
        n = 256;
      end else if (r < 1) begin
        n = $urandom_range(250, 300);
      end else if (r < 9) begin
        n = 0;
      end else begin
        n = $urandom_range(1, 12);
      end
      steady = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < n; k++) begin
        payload.push_back(ByteW'($urandom));
      end
      send_packet(ByteW'($urandom), pick_mode(), 1'($urandom_range(0, 1)));
      packets++;
      // Let the pipeline and its queue run completely dry a couple of times.
      if (packets == 5 || packets == 15) begin
        wait_for_results();
      end
    end

    wait_for_results();
    // Let the clock run on to catch any stray result.
    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // A correct run needs only a small fraction of this, even with every gap and stall long.
  initial begin : watchdog
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
